@@ rtl/apq_pkg.sv @@
// Shared types and constants for the array priority queue.
// Depends on nothing; the top level, the compare unit and the testbench import it.
package apq_pkg;

    localparam int APQ_CAPACITY      = 16;
    localparam int APQ_PAYLOAD_BITS  = 16;
    localparam int APQ_PRIORITY_BITS = 8;
    localparam int APQ_OCC_BITS      = 5;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_POP_MIN = 2'd1,
        CMD_POP_MAX = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_SETUP,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]                   command;
        logic [APQ_PAYLOAD_BITS-1:0]  payload_in;
        logic [APQ_PRIORITY_BITS-1:0] priority_in;
    } t_apq_in;

    typedef struct packed {
        logic [1:0]                  status;
        logic [APQ_PAYLOAD_BITS-1:0] payload_out;
        logic [APQ_OCC_BITS-1:0]     occupancy;
    } t_apq_out;

    // One stored entry, priority in the upper bits.
    typedef struct packed {
        logic [APQ_PRIORITY_BITS-1:0] prio;
        logic [APQ_PAYLOAD_BITS-1:0]  payload;
    } t_entry;

    // Control from the sequencer to the compare unit.
    typedef struct packed {
        logic vld;
        logic first;
        logic want_max;
    } t_scan_ctl;

endpackage

@@ rtl/array_priority_queue.sv @@
// Top level of the array priority queue: sequencer, entry RAM, compare unit.
// Depends on apq_pkg, apq_ram and apq_scan.
//
//  channel   | ports                     | handshake
//  ----------+---------------------------+-----------------------------------
//  command   | start, busy, i_cmd        | taken when start && !busy
//  result    | o_done, o_result          | one-cycle strobe, cannot stall
//
// Insert, overflow and underflow finish in the accept cycle; the result
// word is registered, shows in the cycle after, and busy stays low. A
// remove over n entries reads all n for the compare, settles the pick in
// S_PICK and S_SETUP, shifts the later entries down one per cycle through
// the single RAM port pair, paced by its one read port, and ends in
// S_DONE. A meaningless command code is dropped with no result. Reset
// clears the state, entry count, read tag and result strobe only; RAM
// contents start undefined and are never read before written.
module array_priority_queue #(
    parameter int CAPACITY = apq_pkg::APQ_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  apq_pkg::t_apq_in  i_cmd,
    output logic              busy,
    output logic              o_done,
    output apq_pkg::t_apq_out o_result
);
    import apq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int EW = APQ_PAYLOAD_BITS + APQ_PRIORITY_BITS;
    localparam int OW = APQ_OCC_BITS;

    // Read in flight: which index, and whether it feeds the shift.
    typedef struct packed {
        logic          vld;
        logic          shift;
        logic [IW-1:0] idx;
    } t_rd_tag;

    t_state   r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic     r_want_max, n_want_max;
    t_rd_tag  r_tag, n_tag;
    logic     r_out_vld, n_out_vld;
    t_apq_out r_out, n_out;

    logic          accept;
    logic [CW-1:0] idx_nx;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata_raw;
    t_entry        ram_rdata;
    t_scan_ctl     scan_ctl;
    logic [IW-1:0] best_idx;
    logic [APQ_PAYLOAD_BITS-1:0] best_payload;

    assign accept    = start && !busy;
    assign idx_nx    = r_idx + CW'(1);
    assign ram_rdata = t_entry'(ram_rdata_raw);

    apq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (EW'(ram_wdata)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );

    assign scan_ctl.vld      = r_tag.vld && !r_tag.shift;
    assign scan_ctl.first    = (r_tag.idx == '0);
    assign scan_ctl.want_max = r_want_max;

    apq_scan #(
        .IW (IW)
    ) u_scan (
        .i_clk          (i_clk),
        .i_ctl          (scan_ctl),
        .i_entry        (ram_rdata),
        .i_idx          (r_tag.idx),
        .o_best_idx     (best_idx),
        .o_best_payload (best_payload)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_tag     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_tag     <= n_tag;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_want_max <= n_want_max;
        r_out      <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_want_max = r_want_max;
        n_tag      = '0;
        n_out_vld  = 1'b0;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = r_cnt[IW-1:0];
        ram_wdata  = '0;
        ram_raddr  = r_idx[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.command)
                        CMD_INSERT: begin
                            n_out_vld         = 1'b1;
                            n_out.payload_out = '0;
                            if (r_cnt == CW'(CAPACITY)) begin
                                n_out.status    = ST_OVERFLOW;
                                n_out.occupancy = OW'(r_cnt);
                            end else begin
                                // Append at the tail, arrival order kept.
                                ram_we            = 1'b1;
                                ram_waddr         = r_cnt[IW-1:0];
                                ram_wdata.prio    = i_cmd.priority_in;
                                ram_wdata.payload = i_cmd.payload_in;
                                n_cnt             = r_cnt + CW'(1);
                                n_out.status      = ST_INSERTED;
                                n_out.occupancy   = OW'(r_cnt + CW'(1));
                            end
                        end
                        CMD_POP_MIN, CMD_POP_MAX: begin
                            if (r_cnt == '0) begin
                                n_out_vld         = 1'b1;
                                n_out.status      = ST_UNDERFLOW;
                                n_out.payload_out = '0;
                                n_out.occupancy   = '0;
                            end else begin
                                n_want_max = (i_cmd.command == CMD_POP_MAX);
                                n_idx      = '0;
                                n_state    = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Read every held entry once; the compare unit sees each in the cycle after its read.
                ram_raddr = r_idx[IW-1:0];
                n_tag.vld   = 1'b1;
                n_tag.shift = 1'b0;
                n_tag.idx   = r_idx[IW-1:0];
                n_idx       = idx_nx;
                if (idx_nx == r_cnt) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                // Last entry is compared in this cycle.
                n_state = S_SETUP;
            end
            S_SETUP: begin
                n_idx   = CW'(best_idx);
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                // Read entry j+1 now, write it to entry j next cycle.
                if (idx_nx < r_cnt) begin
                    ram_raddr   = idx_nx[IW-1:0];
                    n_tag.vld   = 1'b1;
                    n_tag.shift = 1'b1;
                    n_tag.idx   = idx_nx[IW-1:0];
                    n_idx       = idx_nx;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_cnt             = r_cnt - CW'(1);
                n_out_vld         = 1'b1;
                n_out.status      = ST_REMOVED;
                n_out.payload_out = best_payload;
                n_out.occupancy   = OW'(r_cnt - CW'(1));
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Land a shift read one place lower.
        if (r_tag.vld && r_tag.shift) begin
            ram_we    = 1'b1;
            ram_waddr = r_tag.idx - IW'(1);
            ram_wdata = ram_rdata;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_out_vld;
    assign o_result = r_out;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_busy_ends_with_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("remove finished without a result word");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_PICK) |-> !ram_we)
        else $error("RAM written during the compare pass");

    a_remove_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt != '0))
        else $error("compare pass over an empty store");

    a_removed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_REMOVED) |-> (r_cnt != CW'(CAPACITY)))
        else $error("count not lowered after a remove");

endmodule

@@ rtl/apq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module apq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/apq_scan.sv @@
// Compare unit for both min and max removes: tracks the oldest entry holding the extreme priority.
// Depends on apq_pkg.
module apq_scan #(
    parameter int IW = 4
) (
    input  logic                                 i_clk,
    input  apq_pkg::t_scan_ctl                   i_ctl,
    input  apq_pkg::t_entry                      i_entry,
    input  logic [IW-1:0]                        i_idx,
    output logic [IW-1:0]                        o_best_idx,
    output logic [apq_pkg::APQ_PAYLOAD_BITS-1:0] o_best_payload
);
    import apq_pkg::*;

    logic [APQ_PRIORITY_BITS-1:0] r_best_prio;
    logic [APQ_PAYLOAD_BITS-1:0]  r_best_payload;
    logic [IW-1:0]                r_best_idx;
    logic                         take;

    // Strict compare keeps the older entry on a tie.
    always_comb begin
        if (i_ctl.first) begin
            take = 1'b1;
        end else if (i_ctl.want_max) begin
            take = i_entry.prio > r_best_prio;
        end else begin
            take = i_entry.prio < r_best_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld && take) begin
            r_best_prio    <= i_entry.prio;
            r_best_payload <= i_entry.payload;
            r_best_idx     <= i_idx;
        end
    end

    assign o_best_idx     = r_best_idx;
    assign o_best_payload = r_best_payload;

endmodule

@@ tb/tb_array_priority_queue.sv @@
// Self-checking testbench for the array priority queue: a directed opening,
// then random insert/remove traffic checked against a behavioral queue model.
// Depends on apq_pkg and the array_priority_queue RTL.
module tb_array_priority_queue;
    import apq_pkg::*;

    // Command code with no meaning; the block drops it without a result.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 1950;
    // Long enough to cover a remove over a full store, with slack on top.
    localparam int TAIL_CYCLES  = 2 * APQ_CAPACITY + 8;
    localparam int DRAIN_QUIET  = 2 * APQ_CAPACITY + 8;
    localparam int CYCLE_LIMIT  = 1000000;

    // One queued stimulus word with the idle gap that precedes it and an
    // optional request to wait for every outstanding result first.
    typedef struct {
        t_apq_in word;
        int      gap;
        bit      drain;
    } t_pending;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_apq_in   cmd_word = '0;
    logic      busy;
    logic      o_done;
    t_apq_out  o_result;

    t_pending  pending_words[$];
    t_apq_out  expected_results[$];

    // Behavioral copy of the store, in arrival order.
    logic [APQ_PAYLOAD_BITS-1:0]  shadow_payload[APQ_CAPACITY];
    logic [APQ_PRIORITY_BITS-1:0] shadow_prio[APQ_CAPACITY];
    int shadow_count = 0;

    int  err_cnt   = 0;
    int  cycle_cnt = 0;
    int  wait_cnt  = 0;
    int  quiet_cnt = 0;
    int  word_cnt  = 0;
    bit  no_idle_phase = 1'b0;

    array_priority_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (cmd_word),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Count cycles and bail out if the block stops answering.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        err_cnt++;
        $display("[cycle %0d] mismatch on %s: expected %0h, got %0h",
                 cycle_cnt, what, want, got);
    endtask

    // Apply one accepted word to the shadow store and queue the result it
    // should produce. Ties keep the oldest entry, since only a strictly
    // better priority moves the pick.
    task automatic apply_to_shadow(input t_apq_in w);
        t_apq_out r;
        int       pick;
        r = '0;
        case (w.command)
            CMD_INSERT: begin
                if (shadow_count >= APQ_CAPACITY) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    shadow_payload[shadow_count] = w.payload_in;
                    shadow_prio[shadow_count]    = w.priority_in;
                    shadow_count++;
                    r.status = ST_INSERTED;
                end
                r.occupancy = APQ_OCC_BITS'(shadow_count);
                expected_results.push_back(r);
            end
            CMD_POP_MIN, CMD_POP_MAX: begin
                if (shadow_count == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    pick = 0;
                    for (int i = 1; i < shadow_count; i++) begin
                        if (w.command == CMD_POP_MAX ? shadow_prio[i] > shadow_prio[pick]
                                                     : shadow_prio[i] < shadow_prio[pick])
                            pick = i;
                    end
                    r.status      = ST_REMOVED;
                    r.payload_out = shadow_payload[pick];
                    // Close the gap, keeping arrival order.
                    for (int j = pick; j + 1 < shadow_count; j++) begin
                        shadow_payload[j] = shadow_payload[j + 1];
                        shadow_prio[j]    = shadow_prio[j + 1];
                    end
                    shadow_count--;
                end
                r.occupancy = APQ_OCC_BITS'(shadow_count);
                expected_results.push_back(r);
            end
            default: begin
                // Unused code: drop it, nothing changes.
            end
        endcase
    endtask

    // Driver: present queued words, hold a word while busy, and idle for the
    // gap attached to each word. A drain word waits until the block has been
    // quiet with nothing expected for a while.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            wait_cnt  <= 0;
            quiet_cnt <= 0;
        end else begin
            if (expected_results.size() == 0 && !busy && !start)
                quiet_cnt <= quiet_cnt + 1;
            else
                quiet_cnt <= 0;

            if (start && !busy)
                apply_to_shadow(cmd_word);

            if (start && busy) begin
                // Hold the word until the block takes it.
            end else if (pending_words.size() != 0 && wait_cnt >= pending_words[0].gap &&
                         (!pending_words[0].drain || quiet_cnt >= DRAIN_QUIET)) begin
                start    <= 1'b1;
                cmd_word <= pending_words[0].word;
                pending_words.delete(0);
                wait_cnt <= 0;
            end else begin
                start    <= 1'b0;
                wait_cnt <= wait_cnt + 1;
            end
        end
    end

    // Monitor: every strobed result must match the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result word", 32'h0, 32'(o_result));
            end else begin
                if (o_result.status !== expected_results[0].status)
                    report_mismatch("status", 32'(expected_results[0].status),
                                    32'(o_result.status));
                if (o_result.payload_out !== expected_results[0].payload_out)
                    report_mismatch("payload_out", 32'(expected_results[0].payload_out),
                                    32'(o_result.payload_out));
                if (o_result.occupancy !== expected_results[0].occupancy)
                    report_mismatch("occupancy", 32'(expected_results[0].occupancy),
                                    32'(o_result.occupancy));
                expected_results.delete(0);
            end
        end
    end

    // Mostly short gaps, some medium, a few long; none in no-idle phases.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle_phase || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    task automatic push_word(input logic [1:0] cmd, input logic [15:0] pay,
                             input logic [7:0] prio, input bit drain);
        t_pending p;
        p.word.command     = cmd;
        p.word.payload_in  = pay;
        p.word.priority_in = prio;
        p.gap              = pick_gap();
        p.drain            = drain;
        pending_words.push_back(p);
    endtask

    initial begin
        int          phase_len;
        int          mode;
        int          insert_pct;
        logic [7:0]  prio;
        logic [1:0]  cmd;

        // Directed opening: underflow both ways, an unused code, fill with
        // extreme and tied priorities, overflow, then pull the extremes.
        push_word(CMD_POP_MIN, 16'h0000, 8'h00, 1'b0);
        push_word(CMD_POP_MAX, 16'hffff, 8'hff, 1'b0);
        push_word(CMD_UNUSED,  16'hffff, 8'hff, 1'b0);
        push_word(CMD_INSERT,  16'h0000, 8'h80, 1'b0);
        push_word(CMD_INSERT,  16'hffff, 8'h00, 1'b0);
        push_word(CMD_INSERT,  16'h5555, 8'hff, 1'b0);
        push_word(CMD_INSERT,  16'haaaa, 8'h00, 1'b0);
        push_word(CMD_INSERT,  16'h1234, 8'hff, 1'b0);
        push_word(CMD_INSERT,  16'h8001, 8'h40, 1'b0);
        push_word(CMD_INSERT,  16'h0001, 8'h7f, 1'b0);
        push_word(CMD_INSERT,  16'hfffe, 8'h00, 1'b0);
        for (int k = 0; k < 8; k++)
            push_word(CMD_INSERT, 16'($urandom), 8'($urandom_range(1, 254)), 1'b0);
        push_word(CMD_INSERT,  16'hbeef, 8'h00, 1'b0);
        push_word(CMD_UNUSED,  16'h0000, 8'h00, 1'b0);
        push_word(CMD_POP_MIN, 16'h0000, 8'h00, 1'b0);
        push_word(CMD_POP_MAX, 16'h0000, 8'h00, 1'b0);
        push_word(CMD_POP_MIN, 16'h0000, 8'h00, 1'b0);

        // Random phases, each biased toward filling, draining, balance or
        // heavy priority ties so that full and empty are both hit often.
        while (word_cnt < RANDOM_WORDS) begin
            phase_len     = $urandom_range(40, 160);
            mode          = $urandom_range(0, 3);
            no_idle_phase = ($urandom_range(0, 4) == 0);
            case (mode)
                0:       insert_pct = 80;
                1:       insert_pct = 20;
                default: insert_pct = 50;
            endcase
            for (int k = 0; k < phase_len && word_cnt < RANDOM_WORDS; k++) begin
                case ($urandom_range(0, 9))
                    0:       prio = 8'h00;
                    1:       prio = 8'hff;
                    2, 3:    prio = 8'($urandom_range(0, 3));
                    default: prio = 8'($urandom);
                endcase
                if (mode == 3)
                    prio = 8'($urandom_range(0, 3));
                if ($urandom_range(0, 99) < 3)
                    cmd = CMD_UNUSED;
                else if ($urandom_range(0, 99) < insert_pct)
                    cmd = CMD_INSERT;
                else
                    cmd = $urandom_range(0, 1) ? CMD_POP_MIN : CMD_POP_MAX;
                // Drain before the first word of the random part and at
                // some phase starts, so the sender pauses for all results.
                push_word(cmd, 16'($urandom), prio,
                          (word_cnt == 0) || (k == 0 && $urandom_range(0, 2) == 0));
                if (cmd != CMD_UNUSED)
                    word_cnt++;
            end
        end
        no_idle_phase = 1'b0;

        // Hold reset low at the start, then release it.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all words to be taken, all results to arrive, then a tail
        // that would expose any stray result.
        while (pending_words.size() != 0 || start) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/apq_pkg.sv
rtl/apq_ram.sv
rtl/apq_scan.sv
rtl/array_priority_queue.sv
tb/tb_array_priority_queue.sv
